FILE: sv/wpp_pkg.sv
// types and constants shared by the wav pcm24 stream parser
package wpp_pkg;

    typedef enum logic [3:0] {
        PH_RIFF         = 4'd0,
        PH_RSIZE        = 4'd1,
        PH_WAVE         = 4'd2,
        PH_CHUNK_ID     = 4'd3,
        PH_FMT_SIZE     = 4'd4,
        PH_DATA_SIZE    = 4'd5,
        PH_OTHER_SIZE   = 4'd6,
        PH_FMT_FC       = 4'd7,
        PH_FMT_RATE     = 4'd8,
        PH_FMT_IGN      = 4'd9,
        PH_FMT_BITS     = 4'd10,
        PH_SKIP         = 4'd11,
        PH_DATA         = 4'd12,
        PH_HALT         = 4'd13,
        PH_PEND_END     = 4'd14,
        PH_PEND_NOAUDIO = 4'd15
    } t_phase;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_FORMAT = 2'd1,
        KIND_ERROR  = 2'd2,
        KIND_END    = 2'd3
    } t_kind;

    localparam logic [2:0] ERR_NOT_RIFF = 3'd0;
    localparam logic [2:0] ERR_NOT_WAVE = 3'd1;
    localparam logic [2:0] ERR_NOT_PCM  = 3'd2;
    localparam logic [2:0] ERR_NOT_24   = 3'd3;
    localparam logic [2:0] ERR_NO_AUDIO = 3'd4;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] FMT_PCM       = 16'd1;
    localparam logic [15:0] BITS_24       = 16'd24;
    localparam logic [31:0] FMT_BODY_SIZE = 32'd16;

    localparam logic [2:0] LEN_WORD = 3'd4;
    localparam logic [2:0] LEN_HALF = 3'd2;
    localparam logic [2:0] LEN_IGN  = 3'd6;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       start_of_file;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic signed [23:0] sample_value;
        logic [15:0]        channel_index;
        logic [15:0]        channel_count;
        logic [31:0]        sample_rate;
        logic [2:0]         error_code;
    } t_out_item;

endpackage

FILE: sv/wpp_core.sv
// parser state machine: chunk walking, fmt fields and sample assembly
module wpp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  wpp_pkg::t_in_item   i_item,
    output logic                o_res_valid,
    output wpp_pkg::t_out_item  o_res
);

    wpp_pkg::t_phase r_phase, n_phase, c_phase;
    logic [2:0]  r_field_cnt, n_field_cnt, c_field_cnt;
    logic [31:0] r_shift, n_shift, c_shift;
    logic [31:0] r_remain, n_remain, c_remain;
    logic [15:0] r_format, n_format, c_format;
    logic [15:0] r_chans, n_chans, c_chans;
    logic [31:0] r_rate, n_rate, c_rate;
    logic [15:0] r_bits, n_bits, c_bits;
    logic [15:0] r_partial, n_partial, c_partial;
    logic [1:0]  r_samp_cnt, n_samp_cnt, c_samp_cnt;
    logic [15:0] r_chan_ctr, n_chan_ctr, c_chan_ctr;

    logic        res_valid;
    wpp_pkg::t_kind res_kind;
    logic [2:0]  res_err;
    logic [23:0] res_sample;
    logic [15:0] res_chan;

    logic [31:0] shifted;
    logic [2:0]  cnt_inc;
    logic [2:0]  need;
    logic        done;
    logic [31:0] rem_dec;
    logic [16:0] chan_next;

    // current state, with start of file restarting the parser
    always_comb begin
        if (i_item.start_of_file) begin
            c_phase     = wpp_pkg::PH_RIFF;
            c_field_cnt = '0;
            c_shift     = '0;
            c_remain    = '0;
            c_format    = '0;
            c_chans     = '0;
            c_rate      = '0;
            c_bits      = '0;
            c_partial   = '0;
            c_samp_cnt  = '0;
            c_chan_ctr  = '0;
        end else begin
            c_phase     = r_phase;
            c_field_cnt = r_field_cnt;
            c_shift     = r_shift;
            c_remain    = r_remain;
            c_format    = r_format;
            c_chans     = r_chans;
            c_rate      = r_rate;
            c_bits      = r_bits;
            c_partial   = r_partial;
            c_samp_cnt  = r_samp_cnt;
            c_chan_ctr  = r_chan_ctr;
        end
    end

    // next state
    always_comb begin
        n_phase     = c_phase;
        n_field_cnt = c_field_cnt;
        n_shift     = c_shift;
        n_remain    = c_remain;
        n_format    = c_format;
        n_chans     = c_chans;
        n_rate      = c_rate;
        n_bits      = c_bits;
        n_partial   = c_partial;
        n_samp_cnt  = c_samp_cnt;
        n_chan_ctr  = c_chan_ctr;
        res_valid   = 1'b0;
        res_kind    = wpp_pkg::KIND_SAMPLE;
        res_err     = wpp_pkg::ERR_NOT_RIFF;
        res_sample  = '0;
        res_chan    = '0;

        shifted   = {i_item.byte_value, c_shift[31:8]};
        cnt_inc   = c_field_cnt + 3'd1;
        rem_dec   = (c_remain != '0) ? c_remain - 32'd1 : '0;
        chan_next = {1'b0, c_chan_ctr} + 17'd1;

        unique case (c_phase)
            wpp_pkg::PH_FMT_IGN:  need = wpp_pkg::LEN_IGN;
            wpp_pkg::PH_FMT_BITS: need = wpp_pkg::LEN_HALF;
            default:              need = wpp_pkg::LEN_WORD;
        endcase
        done = (cnt_inc >= need);

        // field phases shift the byte in
        if (c_phase <= wpp_pkg::PH_FMT_BITS) begin
            n_shift     = shifted;
            n_field_cnt = done ? 3'd0 : cnt_inc;
        end

        unique case (c_phase)
            wpp_pkg::PH_PEND_END: begin
                n_phase   = wpp_pkg::PH_HALT;
                res_valid = 1'b1;
                res_kind  = wpp_pkg::KIND_END;
            end
            wpp_pkg::PH_PEND_NOAUDIO: begin
                n_phase   = wpp_pkg::PH_HALT;
                res_valid = 1'b1;
                res_kind  = wpp_pkg::KIND_ERROR;
                res_err   = wpp_pkg::ERR_NO_AUDIO;
            end
            wpp_pkg::PH_HALT: begin
                n_phase = wpp_pkg::PH_HALT;
            end
            wpp_pkg::PH_RIFF: begin
                if (done) begin
                    if (shifted != wpp_pkg::TAG_RIFF) begin
                        n_phase   = wpp_pkg::PH_HALT;
                        res_valid = 1'b1;
                        res_kind  = wpp_pkg::KIND_ERROR;
                        res_err   = wpp_pkg::ERR_NOT_RIFF;
                    end else begin
                        n_phase = wpp_pkg::PH_RSIZE;
                    end
                end
            end
            wpp_pkg::PH_RSIZE: begin
                if (done) n_phase = wpp_pkg::PH_WAVE;
            end
            wpp_pkg::PH_WAVE: begin
                if (done) begin
                    if (shifted != wpp_pkg::TAG_WAVE) begin
                        n_phase   = wpp_pkg::PH_HALT;
                        res_valid = 1'b1;
                        res_kind  = wpp_pkg::KIND_ERROR;
                        res_err   = wpp_pkg::ERR_NOT_WAVE;
                    end else begin
                        n_phase = wpp_pkg::PH_CHUNK_ID;
                    end
                end
            end
            wpp_pkg::PH_CHUNK_ID: begin
                if (done) begin
                    if (shifted == wpp_pkg::TAG_FMT)       n_phase = wpp_pkg::PH_FMT_SIZE;
                    else if (shifted == wpp_pkg::TAG_DATA) n_phase = wpp_pkg::PH_DATA_SIZE;
                    else                                   n_phase = wpp_pkg::PH_OTHER_SIZE;
                end
            end
            wpp_pkg::PH_FMT_SIZE: begin
                if (done) begin
                    n_remain = shifted;
                    n_phase  = wpp_pkg::PH_FMT_FC;
                end
            end
            wpp_pkg::PH_DATA_SIZE: begin
                if (done) begin
                    if (shifted == '0) begin
                        n_phase   = wpp_pkg::PH_HALT;
                        res_valid = 1'b1;
                        res_kind  = wpp_pkg::KIND_ERROR;
                        res_err   = wpp_pkg::ERR_NO_AUDIO;
                    end else begin
                        n_remain   = shifted;
                        n_samp_cnt = '0;
                        n_partial  = '0;
                        n_chan_ctr = '0;
                        n_phase    = wpp_pkg::PH_DATA;
                    end
                end
            end
            wpp_pkg::PH_OTHER_SIZE: begin
                if (done) begin
                    n_remain = shifted;
                    n_phase  = (shifted != '0) ? wpp_pkg::PH_SKIP : wpp_pkg::PH_CHUNK_ID;
                end
            end
            wpp_pkg::PH_FMT_FC: begin
                if (done) begin
                    n_format = shifted[15:0];
                    n_chans  = shifted[31:16];
                    n_phase  = wpp_pkg::PH_FMT_RATE;
                end
            end
            wpp_pkg::PH_FMT_RATE: begin
                if (done) begin
                    n_rate  = shifted;
                    n_phase = wpp_pkg::PH_FMT_IGN;
                end
            end
            wpp_pkg::PH_FMT_IGN: begin
                if (done) n_phase = wpp_pkg::PH_FMT_BITS;
            end
            wpp_pkg::PH_FMT_BITS: begin
                if (done) begin
                    n_bits = shifted[31:16];
                    if (c_format != wpp_pkg::FMT_PCM) begin
                        n_phase   = wpp_pkg::PH_HALT;
                        res_valid = 1'b1;
                        res_kind  = wpp_pkg::KIND_ERROR;
                        res_err   = wpp_pkg::ERR_NOT_PCM;
                    end else if (shifted[31:16] != wpp_pkg::BITS_24) begin
                        n_phase   = wpp_pkg::PH_HALT;
                        res_valid = 1'b1;
                        res_kind  = wpp_pkg::KIND_ERROR;
                        res_err   = wpp_pkg::ERR_NOT_24;
                    end else begin
                        res_valid = 1'b1;
                        res_kind  = wpp_pkg::KIND_FORMAT;
                        if (c_remain > wpp_pkg::FMT_BODY_SIZE) begin
                            n_remain = c_remain - wpp_pkg::FMT_BODY_SIZE;
                            n_phase  = wpp_pkg::PH_SKIP;
                        end else begin
                            n_remain = '0;
                            n_phase  = wpp_pkg::PH_CHUNK_ID;
                        end
                    end
                end
            end
            wpp_pkg::PH_SKIP: begin
                n_remain = rem_dec;
                if (rem_dec == '0) n_phase = wpp_pkg::PH_CHUNK_ID;
            end
            wpp_pkg::PH_DATA: begin
                unique case (c_samp_cnt)
                    2'd0: begin
                        n_partial  = {8'd0, i_item.byte_value};
                        n_samp_cnt = 2'd1;
                    end
                    2'd1: begin
                        n_partial  = {i_item.byte_value, c_partial[7:0]};
                        n_samp_cnt = 2'd2;
                    end
                    default: begin
                        res_valid  = 1'b1;
                        res_kind   = wpp_pkg::KIND_SAMPLE;
                        res_sample = {i_item.byte_value, c_partial};
                        res_chan   = c_chan_ctr;
                        n_chan_ctr = (chan_next >= {1'b0, c_chans}) ? '0 : chan_next[15:0];
                        n_samp_cnt = 2'd0;
                    end
                endcase
                n_remain = rem_dec;
                if (rem_dec == '0) begin
                    if (res_valid) begin
                        n_phase = wpp_pkg::PH_PEND_END;
                    end else begin
                        res_valid = 1'b1;
                        res_kind  = wpp_pkg::KIND_END;
                        n_phase   = wpp_pkg::PH_HALT;
                    end
                end
            end
        endcase

        // early end of stream
        if (i_item.end_of_stream && n_phase != wpp_pkg::PH_HALT &&
            n_phase != wpp_pkg::PH_PEND_END && n_phase != wpp_pkg::PH_PEND_NOAUDIO) begin
            priority if (res_valid && res_kind == wpp_pkg::KIND_SAMPLE) begin
                n_phase = wpp_pkg::PH_PEND_END;
            end else if (res_valid && res_kind == wpp_pkg::KIND_FORMAT) begin
                n_phase = wpp_pkg::PH_PEND_NOAUDIO;
            end else if (n_phase == wpp_pkg::PH_DATA) begin
                res_valid = 1'b1;
                res_kind  = wpp_pkg::KIND_END;
                n_phase   = wpp_pkg::PH_HALT;
            end else begin
                res_valid = 1'b1;
                res_kind  = wpp_pkg::KIND_ERROR;
                if (n_phase == wpp_pkg::PH_RIFF)
                    res_err = wpp_pkg::ERR_NOT_RIFF;
                else if (n_phase == wpp_pkg::PH_RSIZE || n_phase == wpp_pkg::PH_WAVE)
                    res_err = wpp_pkg::ERR_NOT_WAVE;
                else
                    res_err = wpp_pkg::ERR_NO_AUDIO;
                n_phase = wpp_pkg::PH_HALT;
            end
        end
    end

    // result fields, zero where unused
    always_comb begin
        o_res_valid = res_valid;
        o_res       = '0;
        o_res.result_kind = res_kind;
        unique case (res_kind)
            wpp_pkg::KIND_SAMPLE: begin
                o_res.sample_value  = res_sample;
                o_res.channel_index = res_chan;
            end
            wpp_pkg::KIND_FORMAT: begin
                o_res.channel_count = c_chans;
                o_res.sample_rate   = c_rate;
            end
            wpp_pkg::KIND_ERROR: begin
                o_res.error_code = res_err;
            end
            default: begin
                o_res.error_code = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= wpp_pkg::PH_RIFF;
            r_field_cnt <= '0;
            r_shift     <= '0;
            r_remain    <= '0;
            r_format    <= '0;
            r_chans     <= '0;
            r_rate      <= '0;
            r_bits      <= '0;
            r_partial   <= '0;
            r_samp_cnt  <= '0;
            r_chan_ctr  <= '0;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_field_cnt <= n_field_cnt;
            r_shift     <= n_shift;
            r_remain    <= n_remain;
            r_format    <= n_format;
            r_chans     <= n_chans;
            r_rate      <= n_rate;
            r_bits      <= n_bits;
            r_partial   <= n_partial;
            r_samp_cnt  <= n_samp_cnt;
            r_chan_ctr  <= n_chan_ctr;
        end
    end

    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && res_valid && res_kind == wpp_pkg::KIND_ERROR |=> r_phase == wpp_pkg::PH_HALT)
        else $error("error result without halting");

    a_samp_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_samp_cnt != 2'd3)
        else $error("sample byte count out of range");

    a_field_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_field_cnt <= 3'd5)
        else $error("field byte count out of range");

    a_bits_checked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && res_valid && res_kind == wpp_pkg::KIND_FORMAT |=> r_bits == wpp_pkg::BITS_24)
        else $error("format result with bit depth other than 24");

endmodule

FILE: sv/wav_pcm24_stream_parser.sv
// top level of the wav pcm24 stream parser with its result register
//
// takes a wav file one byte per request on the input channel
// (i_in_valid / o_in_stall / i_in_item) and gives results on the output
// channel (o_out_valid / i_out_stall / o_out_item)
// results: one format result after a valid fmt chunk, one 24-bit sample for
// every three bytes of the data chunk, then an end result, or an error code
// throughput: one byte per cycle, also while results flow out, unless the receiver stalls a full result register
// a result is registered and appears on the output in the cycle after the byte that
// causes it; a second result owed by that byte comes with the next byte
// the parser logic sits between the state registers and the result register
// set start_of_file on the first byte of every file to restart the parser
// reset (synchronous, active low) returns the parser to the riff tag and
// empties the result register
// when the receiver stalls, the result register holds its request and the
// input is stalled only while that register is full
module wav_pcm24_stream_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  wpp_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output wpp_pkg::t_out_item  o_out_item
);

    logic               accept;
    logic               res_valid;
    wpp_pkg::t_out_item res;
    logic               r_out_valid;
    wpp_pkg::t_out_item r_out_item;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    wpp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (accept),
        .i_item      (i_in_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out_item))
        else $error("stalled result lost or changed");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && res_valid |=> r_out_valid)
        else $error("result not registered");

    a_idle_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(accept && res_valid) && !i_out_stall |=> !r_out_valid)
        else $error("result repeated");

endmodule
